// File: hdl/iasc_pkg.sv
// ----------------------------------------------------------------------------
// iasc_pkg
// shared types, register codes and constants of the adaptive step controller
// ----------------------------------------------------------------------------
package iasc_pkg;

	localparam int TABLE_ENTRIES  = 4;
	localparam int TIME_FRAC_BITS = 24;
	localparam int WORD_ENTRIES   = 4;
	localparam int USED_MAX       = (TABLE_ENTRIES < WORD_ENTRIES) ? TABLE_ENTRIES
	                                                               : WORD_ENTRIES;

	localparam int TIME_W  = 48;
	localparam int INDEX_W = 32;
	localparam int ITER_W  = 16;
	localparam int MULT_W  = 16;
	localparam int COUNT_W = 3;
	localparam int DATA_W  = 64;
	localparam int ADDR_W  = 6;

	localparam logic [2:0] REG_SPAN_END     = 3'd0;
	localparam logic [2:0] REG_MIN_STEP     = 3'd1;
	localparam logic [2:0] REG_MAX_STEP     = 3'd2;
	localparam logic [2:0] REG_INITIAL_STEP = 3'd3;
	localparam logic [2:0] REG_THRESHOLDS   = 3'd4;
	localparam logic [2:0] REG_MULTIPLIERS  = 3'd5;
	localparam logic [2:0] REG_ENTRY_COUNT  = 3'd6;

	localparam logic [MULT_W-1:0] MULT_ONE        = 16'h0100;
	localparam logic [TIME_W-1:0] MAX_STEP_RST    = '1;
	localparam logic [TIME_W-1:0] INIT_STEP_RST   = TIME_W'(64'd1 << TIME_FRAC_BITS);
	localparam logic [DATA_W-1:0] MULT_WORDS_RST  = 64'h0100_0100_0100_0100;

	typedef struct packed {
		logic [TIME_W-1:0]  span_end;
		logic [TIME_W-1:0]  min_step;
		logic [TIME_W-1:0]  max_step;
		logic [TIME_W-1:0]  initial_step;
		logic [DATA_W-1:0]  threshold_words;
		logic [DATA_W-1:0]  multiplier_words;
		logic [COUNT_W-1:0] entry_count;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]  prev_time;
		logic [TIME_W-1:0]  prev_size;
		logic [INDEX_W-1:0] prev_index;
		logic [TIME_W-1:0]  cur_time;
		logic [TIME_W-1:0]  cur_size;
		logic [INDEX_W-1:0] cur_index;
		logic [INDEX_W-1:0] rejected_count;
	} state_t;

	typedef struct packed {
		logic               running;
		logic               step_accepted;
		logic [TIME_W-1:0]  step_time;
		logic [TIME_W-1:0]  step_size;
		logic [INDEX_W-1:0] step_number;
		logic [INDEX_W-1:0] rejected_total;
	} result_t;

endpackage

// File: hdl/iasc_cfg_regs.sv
// ----------------------------------------------------------------------------
// iasc_cfg_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module iasc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [iasc_pkg::ADDR_W-1:0]   paddr,
	input  logic [iasc_pkg::DATA_W-1:0]   pwdata,
	output logic [iasc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output iasc_pkg::cfg_t                cfg
);

	iasc_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[iasc_pkg::ADDR_W-1:3];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.span_end         <= '0;
			cfg_q.min_step         <= '0;
			cfg_q.max_step         <= iasc_pkg::MAX_STEP_RST;
			cfg_q.initial_step     <= iasc_pkg::INIT_STEP_RST;
			cfg_q.threshold_words  <= '0;
			cfg_q.multiplier_words <= iasc_pkg::MULT_WORDS_RST;
			cfg_q.entry_count      <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				iasc_pkg::REG_SPAN_END:     cfg_q.span_end <= pwdata[iasc_pkg::TIME_W-1:0];
				iasc_pkg::REG_MIN_STEP:     cfg_q.min_step <= pwdata[iasc_pkg::TIME_W-1:0];
				iasc_pkg::REG_MAX_STEP:     cfg_q.max_step <= pwdata[iasc_pkg::TIME_W-1:0];
				iasc_pkg::REG_INITIAL_STEP: begin
					cfg_q.initial_step <= pwdata[iasc_pkg::TIME_W-1:0];
				end
				iasc_pkg::REG_THRESHOLDS:   cfg_q.threshold_words <= pwdata;
				iasc_pkg::REG_MULTIPLIERS:  cfg_q.multiplier_words <= pwdata;
				iasc_pkg::REG_ENTRY_COUNT:  begin
					cfg_q.entry_count <= pwdata[iasc_pkg::COUNT_W-1:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			iasc_pkg::REG_SPAN_END:     prdata = iasc_pkg::DATA_W'(cfg_q.span_end);
			iasc_pkg::REG_MIN_STEP:     prdata = iasc_pkg::DATA_W'(cfg_q.min_step);
			iasc_pkg::REG_MAX_STEP:     prdata = iasc_pkg::DATA_W'(cfg_q.max_step);
			iasc_pkg::REG_INITIAL_STEP: prdata = iasc_pkg::DATA_W'(cfg_q.initial_step);
			iasc_pkg::REG_THRESHOLDS:   prdata = cfg_q.threshold_words;
			iasc_pkg::REG_MULTIPLIERS:  prdata = cfg_q.multiplier_words;
			iasc_pkg::REG_ENTRY_COUNT:  prdata = iasc_pkg::DATA_W'(cfg_q.entry_count);
			default:                    prdata = '0;
		endcase
	end

endmodule

// File: hdl/iasc_step_calc.sv
// ----------------------------------------------------------------------------
// iasc_step_calc
// accept decision, multiplier lookup, size product, clamp and end cut
// ----------------------------------------------------------------------------
module iasc_step_calc (
	input  iasc_pkg::cfg_t                cfg,
	input  iasc_pkg::state_t              st,
	input  logic [iasc_pkg::ITER_W-1:0]   iterations,
	output iasc_pkg::state_t              nxt,
	output iasc_pkg::result_t             res
);

	logic [iasc_pkg::ITER_W-1:0] thr [iasc_pkg::WORD_ENTRIES];
	logic [iasc_pkg::MULT_W-1:0] mul [iasc_pkg::WORD_ENTRIES];

	always_comb begin
		for (int i = 0; i < iasc_pkg::WORD_ENTRIES; i++) begin
			thr[i] = cfg.threshold_words[16*i +: 16];
			mul[i] = cfg.multiplier_words[16*i +: 16];
		end
	end

	always_comb begin
		logic [iasc_pkg::COUNT_W-1:0] used;
		logic [1:0]                   lim_idx;
		logic [iasc_pkg::ITER_W-1:0]  limit;
		logic                         run;
		logic                         acc;
		logic [iasc_pkg::MULT_W-1:0]  mult;
		logic [iasc_pkg::TIME_W-1:0]  base_time;
		logic [iasc_pkg::TIME_W-1:0]  base_size;
		logic [iasc_pkg::INDEX_W-1:0] base_index;
		logic [63:0]                  prod;
		logic [55:0]                  scaled;
		logic [iasc_pkg::TIME_W-1:0]  dt;
		logic [iasc_pkg::TIME_W:0]    end_sum;

		used = (cfg.entry_count > iasc_pkg::COUNT_W'(iasc_pkg::USED_MAX))
		       ? iasc_pkg::COUNT_W'(iasc_pkg::USED_MAX) : cfg.entry_count;
		lim_idx = 2'(used - 3'd1);
		limit   = (used != '0) ? thr[lim_idx] : '0;
		run     = (st.cur_time != cfg.span_end);
		acc     = run && (iterations <= limit);

		base_time  = acc ? st.cur_time  : st.prev_time;
		base_size  = acc ? st.cur_size  : st.prev_size;
		base_index = acc ? st.cur_index : st.prev_index;

		// last threshold exceeded picks the multiplier
		mult = (used != '0) ? mul[0] : iasc_pkg::MULT_ONE;
		for (int i = 0; i < iasc_pkg::WORD_ENTRIES; i++) begin
			if ((3'(i) < used) && (iterations > thr[i])) begin
				mult = mul[i];
			end
		end

		prod   = 64'(base_size) * 64'(mult);
		scaled = prod[63:8];

		if (base_index == '0) begin
			dt = cfg.initial_step;
		end else if (|scaled[55:48]) begin
			dt = '1;
		end else begin
			dt = scaled[47:0];
		end

		if (dt < cfg.min_step) begin
			dt = cfg.min_step;
		end else if (dt > cfg.max_step) begin
			dt = cfg.max_step;
		end

		end_sum = {1'b0, dt} + {1'b0, base_time};
		if (end_sum > {1'b0, cfg.span_end}) begin
			dt = (cfg.span_end > base_time) ? (cfg.span_end - base_time) : '0;
		end

		nxt = st;
		if (run) begin
			nxt.prev_time  = base_time;
			nxt.prev_size  = base_size;
			nxt.prev_index = base_index;
			nxt.cur_time   = base_time + dt;
			nxt.cur_size   = dt;
			nxt.cur_index  = base_index + 32'd1;
			if (!acc && (st.rejected_count != '1)) begin
				nxt.rejected_count = st.rejected_count + 32'd1;
			end
		end

		res.running        = run;
		res.step_accepted  = acc;
		res.step_time      = nxt.cur_time;
		res.step_size      = nxt.cur_size;
		res.step_number    = nxt.cur_index;
		res.rejected_total = nxt.rejected_count;
	end

endmodule

// File: hdl/iteration_adaptive_step_control_core.sv
// ----------------------------------------------------------------------------
// iteration_adaptive_step_control_core
// iteration count driven step size controller, one report per word
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------
//   item     | item_valid / item_stall    | iterations
//   result   | result_valid / result_stall| running, step_accepted,
//            |                            | step_time, step_size,
//            |                            | step_number, rejected_total
//   config   | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// one word per cycle sustained while result_stall is not held
// the input register and result register are the two stages; controller
// state updates as a word moves from the input register to the result
// reset clears the controller state and valid flags, no clearing pass
// a held result_stall backs up into item_stall once the input register fills
// ----------------------------------------------------------------------------
module iteration_adaptive_step_control_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [iasc_pkg::ITER_W-1:0]     iterations,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            running,
	output logic                            step_accepted,
	output logic [iasc_pkg::TIME_W-1:0]     step_time,
	output logic [iasc_pkg::TIME_W-1:0]     step_size,
	output logic [iasc_pkg::INDEX_W-1:0]    step_number,
	output logic [iasc_pkg::INDEX_W-1:0]    rejected_total,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [iasc_pkg::ADDR_W-1:0]     paddr,
	input  logic [iasc_pkg::DATA_W-1:0]     pwdata,
	output logic [iasc_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	iasc_pkg::cfg_t               cfg;
	iasc_pkg::state_t             state_q;
	iasc_pkg::state_t             state_nxt;
	iasc_pkg::result_t            res_calc;
	iasc_pkg::result_t            result_q;
	logic                         valid_s1;
	logic [iasc_pkg::ITER_W-1:0]  iterations_s1;
	logic                         result_valid_q;
	logic                         advance;

	iasc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	iasc_step_calc u_calc (
		.cfg        (cfg),
		.st         (state_q),
		.iterations (iterations_s1),
		.nxt        (state_nxt),
		.res        (res_calc)
	);

	assign advance    = valid_s1 & (~result_valid_q | ~result_stall);
	assign item_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			iterations_s1 <= iterations;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			state_q        <= state_nxt;
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_calc;
		end
	end

	assign result_valid   = result_valid_q;
	assign running        = result_q.running;
	assign step_accepted  = result_q.step_accepted;
	assign step_time      = result_q.step_time;
	assign step_size      = result_q.step_size;
	assign step_number    = result_q.step_number;
	assign rejected_total = result_q.rejected_total;

	// rejected count only moves up
	a_rej_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> state_q.rejected_count >= $past(state_q.rejected_count))
		else $error("rejected count decreased");

	// end reached leaves the step state untouched
	a_end_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !res_calc.running |=>
			$stable(state_q.cur_time) && $stable(state_q.cur_index))
		else $error("state changed after end reached");

	// an accepted step is always a running one
	a_acc_running: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.step_accepted |-> result_q.running)
		else $error("accepted without running");

	// backpressure only with a word waiting in the input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid_q && result_stall)
		else $error("item stall without a blocked word");

endmodule
